@@ sv/ipat_pkg.sv @@
// ipat_pkg: types, character codes and helpers shared by the address text parser.
// No dependencies; compiled first.
package ipat_pkg;

  localparam int unsigned NUM_GROUPS = 8;
  localparam int unsigned V4_PARTS   = 4;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] DEC_RADIX = 8'd10;

  // bad flag bits
  localparam logic [1:0] BAD_V4 = 2'b01;
  localparam logic [1:0] BAD_V6 = 2'b10;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_IPV4 = 2'd1,
    KIND_IPV6 = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [63:0]  addr_hi;
    logic [63:0]  addr_lo;
  } result_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        hex_digit = {1'b1, d[3:0]};
      end else if (c >= CH_UC_A && c <= CH_UC_F) begin
        d = c - CH_UC_A + 8'd10;
        hex_digit = {1'b1, d[3:0]};
      end else if (c >= CH_LC_A && c <= CH_LC_F) begin
        d = c - CH_LC_A + 8'd10;
        hex_digit = {1'b1, d[3:0]};
      end else begin
        hex_digit = 5'd0;
      end
    end
  endfunction

endpackage

@@ sv/ipat_if.sv @@
// ipat_in_if / ipat_out_if: valid/ready channels of the address text parser.
// Depends on ipat_pkg.
interface ipat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ipat_out_if;
  logic            valid;
  logic            ready;
  ipat_pkg::kind_t kind;
  logic [63:0]     addr_hi;
  logic [63:0]     addr_lo;

  modport source (output valid, output kind, output addr_hi, output addr_lo, input ready);
  modport sink   (input valid, input kind, input addr_hi, input addr_lo, output ready);
endinterface

@@ sv/ip_address_text_parser.sv @@
// ip_address_text_parser: streams address text and returns IPv4 / IPv6 binary form.
// Depends on ipat_pkg and the channel interfaces in ipat_if.sv.
//
//   channel  | dir | payload                       | transaction
//   ---------+-----+-------------------------------+-----------------------------
//   in_ch    | in  | char_code[7:0], last          | one character of the text
//   out_ch   | out | kind[1:0], addr_hi, addr_lo   | one parsed address per string
//
// Cycles: one character per cycle while in_ch.ready is high; each character
// updates the parse state at the edge that accepts it, and the last character's
// result is written to the output register at that edge, or to the skid if held.
// Reset: synchronous, active-low rst_n clears counts, flags and valids.
// Stalls: a one-entry skid register behind the output register lets input keep
// flowing while a result waits; in_ch.ready drops only when both are full.
module ip_address_text_parser (
  input  logic           clk,
  input  logic           rst_n,
  ipat_in_if.sink        in_ch,
  ipat_out_if.source     out_ch
);
  import ipat_pkg::*;

  // ---------------------------------------------------------------- state
  // IPv4 side: completed bytes, part count, running part value
  logic [7:0]  v4_bytes_r [V4_PARTS];
  logic [2:0]  v4_count_r;
  logic [7:0]  v4_value_r;
  // IPv6 side: head groups indexed from 0; tail groups kept right-aligned in
  // a shift line (newest at slot 7) so the final merge reads fixed slots only
  logic [15:0] head_r [NUM_GROUPS];
  logic [3:0]  head_count_r;
  logic [15:0] tail_r [NUM_GROUPS];
  logic [3:0]  tail_count_r;
  logic        in_tail_r;
  logic [15:0] v6_value_r;
  logic [1:0]  bad_r;
  logic        prev_colon_r;
  logic        stopped_r;

  logic [7:0]  v4_bytes_nxt [V4_PARTS];
  logic [2:0]  v4_count_nxt;
  logic [7:0]  v4_value_nxt;
  logic [15:0] head_nxt [NUM_GROUPS];
  logic [3:0]  head_count_nxt;
  logic [15:0] tail_nxt [NUM_GROUPS];
  logic [3:0]  tail_count_nxt;
  logic        in_tail_nxt;
  logic [15:0] v6_value_nxt;
  logic [1:0]  bad_nxt;
  logic        prev_colon_nxt;
  logic        stopped_nxt;

  // output register and skid
  logic        out_valid_r;
  result_t     out_r;
  logic        skid_valid_r;
  result_t     skid_r;

  logic        accept;
  logic        out_free;
  result_t     res;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !skid_valid_r;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.kind    = out_r.kind;
  assign out_ch.addr_hi = out_r.addr_hi;
  assign out_ch.addr_lo = out_r.addr_lo;

  // ------------------------------------------------------ per-char update
  always_comb begin
    logic [7:0]  c;
    logic [4:0]  hx;
    logic [3:0]  cnt;
    logic [4:0]  total;
    logic [7:0]  b [V4_PARTS];
    logic [15:0] g [NUM_GROUPS];

    c  = in_ch.char_code;
    hx = hex_digit(c);

    v4_bytes_nxt   = v4_bytes_r;
    v4_count_nxt   = v4_count_r;
    v4_value_nxt   = v4_value_r;
    head_nxt       = head_r;
    head_count_nxt = head_count_r;
    tail_nxt       = tail_r;
    tail_count_nxt = tail_count_r;
    in_tail_nxt    = in_tail_r;
    v6_value_nxt   = v6_value_r;
    bad_nxt        = bad_r;
    prev_colon_nxt = prev_colon_r;
    stopped_nxt    = stopped_r;
    cnt            = 4'd0;
    total          = 5'd0;
    res            = '{kind: KIND_NONE, addr_hi: 64'd0, addr_lo: 64'd0};
    for (int i = 0; i < V4_PARTS; i++) b[i] = 8'd0;
    for (int i = 0; i < NUM_GROUPS; i++) g[i] = 16'd0;

    // characters are skipped after '/' and once both readings have failed
    if (!stopped_r && bad_r != (BAD_V4 | BAD_V6)) begin
      if (c == CH_SLASH) begin
        stopped_nxt = 1'b1;
      end else begin
        // IPv4 reading; ignored past the fourth dot
        if (!v4_count_r[2] && !bad_r[0]) begin
          if (c == CH_DOT) begin
            v4_bytes_nxt[v4_count_r[1:0]] = v4_value_r;
            v4_count_nxt = v4_count_r + 3'd1;
            v4_value_nxt = 8'd0;
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            v4_value_nxt = 8'(v4_value_r * DEC_RADIX + (c - CH_ZERO));
          end else begin
            bad_nxt = bad_nxt | BAD_V4;
          end
        end

        // IPv6 reading; ignored while the current half is full
        cnt = in_tail_r ? tail_count_r : head_count_r;
        if (!cnt[3] && !bad_r[1]) begin
          if (c == CH_COLON) begin
            if (prev_colon_r) begin
              if (!in_tail_r) in_tail_nxt = 1'b1;
              else            bad_nxt = bad_nxt | BAD_V6;
            end else begin
              // close the running group
              if (in_tail_r) begin
                if (!tail_count_r[3]) begin
                  for (int i = 0; i < NUM_GROUPS - 1; i++) tail_nxt[i] = tail_r[i+1];
                  tail_nxt[NUM_GROUPS-1] = v6_value_r;
                  tail_count_nxt = tail_count_r + 4'd1;
                end
              end else if (!head_count_r[3]) begin
                head_nxt[head_count_r[2:0]] = v6_value_r;
                head_count_nxt = head_count_r + 4'd1;
              end
              v6_value_nxt = 16'd0;
            end
          end else if (hx[4]) begin
            v6_value_nxt = {v6_value_r[11:0], hx[3:0]};
          end else begin
            bad_nxt = bad_nxt | BAD_V6;
          end
        end

        prev_colon_nxt = (c == CH_COLON);
      end
    end

    // ---------------------------------------------- end of string: merge
    if (in_ch.last) begin
      if (!v4_count_nxt[2]) begin
        v4_bytes_nxt[v4_count_nxt[1:0]] = v4_value_nxt;
        v4_count_nxt = v4_count_nxt + 3'd1;
      end
      if (in_tail_nxt) begin
        if (!tail_count_nxt[3]) begin
          for (int i = 0; i < NUM_GROUPS - 1; i++) tail_nxt[i] = tail_nxt[i+1];
          tail_nxt[NUM_GROUPS-1] = v6_value_nxt;
          tail_count_nxt = tail_count_nxt + 4'd1;
        end
      end else if (!head_count_nxt[3]) begin
        head_nxt[head_count_nxt[2:0]] = v6_value_nxt;
        head_count_nxt = head_count_nxt + 4'd1;
      end
      total = {1'b0, head_count_nxt} + {1'b0, tail_count_nxt};
      if (total > 5'(NUM_GROUPS)) bad_nxt = bad_nxt | BAD_V6;

      if (bad_nxt == BAD_V6) begin
        for (int i = 0; i < V4_PARTS; i++)
          b[i] = (3'(i) < v4_count_nxt) ? v4_bytes_nxt[i] : 8'd0;
        res.kind    = KIND_IPV4;
        res.addr_hi = {b[0], b[1], b[2], b[3], 32'd0};
      end else if (bad_nxt == BAD_V4) begin
        // head from the left, tail right-aligned, zeros in the gap
        for (int j = 0; j < NUM_GROUPS; j++) begin
          if (4'(j) < head_count_nxt)
            g[j] = head_nxt[j];
          else if (5'(j) >= 5'(NUM_GROUPS) - {1'b0, tail_count_nxt})
            g[j] = tail_nxt[j];
        end
        res.kind    = KIND_IPV6;
        res.addr_hi = {g[0], g[1], g[2], g[3]};
        res.addr_lo = {g[4], g[5], g[6], g[7]};
      end

      // back to the start-of-string state
      v4_count_nxt   = 3'd0;
      v4_value_nxt   = 8'd0;
      head_count_nxt = 4'd0;
      tail_count_nxt = 4'd0;
      in_tail_nxt    = 1'b0;
      v6_value_nxt   = 16'd0;
      bad_nxt        = 2'd0;
      prev_colon_nxt = 1'b0;
      stopped_nxt    = 1'b0;
    end
  end

  // ---------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_count_r   <= 3'd0;
      v4_value_r   <= 8'd0;
      head_count_r <= 4'd0;
      tail_count_r <= 4'd0;
      in_tail_r    <= 1'b0;
      v6_value_r   <= 16'd0;
      bad_r        <= 2'd0;
      prev_colon_r <= 1'b0;
      stopped_r    <= 1'b0;
    end else if (accept) begin
      v4_count_r   <= v4_count_nxt;
      v4_value_r   <= v4_value_nxt;
      head_count_r <= head_count_nxt;
      tail_count_r <= tail_count_nxt;
      in_tail_r    <= in_tail_nxt;
      v6_value_r   <= v6_value_nxt;
      bad_r        <= bad_nxt;
      prev_colon_r <= prev_colon_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // group and byte storage: only entries covered by a count are ever read
  always_ff @(posedge clk) begin
    if (accept) begin
      v4_bytes_r <= v4_bytes_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
    end
  end

  // output register with skid; ready low only while the skid is occupied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && in_ch.last;
      end
    end else if (accept && in_ch.last) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (accept && in_ch.last) begin
      skid_r <= res;
    end
  end

endmodule
